// ===== rtl/core/gas_sensor_frame_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Gas sensor frame parser assertion macros
// Shared forms for clocked assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH
`define GAS_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH

// Check prop at every rising clock edge outside reset.
`define GSFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond at one edge implies nxt at the following edge.
`define GSFP_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error(msg);

`endif

// ===== rtl/core/gsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Gas sensor frame parser package
// Frame layout constants, register map and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsfp_pkg;

   localparam int BYTE_W      = 8;
   localparam int READING_W   = 16;
   localparam int COUNT_W     = 4;
   localparam int PENDING_DEPTH = 6;
   localparam int PENDING_IDX_W = $clog2(PENDING_DEPTH);

   // Frame positions: header at 0, readings at 2..7, checksum at 8.
   localparam logic [COUNT_W-1:0] FIRST_POS      = 4'd1;
   localparam logic [COUNT_W-1:0] FIRST_DATA_POS = 4'd2;
   localparam logic [COUNT_W-1:0] CHECKSUM_POS   = 4'd8;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h2C;

   // Register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_HEADER = 1'b0;

   typedef struct packed {
      logic                 frame_valid;
      logic [READING_W-1:0] voc_reading;
      logic [READING_W-1:0] hcho_reading;
      logic [READING_W-1:0] co2_reading;
   } result_type;

endpackage

// ===== rtl/core/gas_sensor_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// Gas sensor frame parser core: header hunt, 9-byte frame, additive checksum
// The result is registered at the checksum byte. Throughput: one byte per
// cycle, set by the single parse stage, while the one-entry skid is empty.
// Reset (synchronous): idle, readings 0, header register 0x2C, no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gas_sensor_frame_parser_core (
   input  logic                               clock,
   input  logic                               reset,
   // input byte channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [gsfp_pkg::BYTE_W-1:0]        req_rx_byte,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_frame_valid,
   output logic [gsfp_pkg::READING_W-1:0]     rsp_voc_reading,
   output logic [gsfp_pkg::READING_W-1:0]     rsp_hcho_reading,
   output logic [gsfp_pkg::READING_W-1:0]     rsp_co2_reading,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gsfp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gsfp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gsfp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [gsfp_pkg::BYTE_W-1:0]    header_ff;
   logic                           in_frame_ff, in_frame_in;
   logic [gsfp_pkg::COUNT_W-1:0]   byte_count_ff, byte_count_in;
   logic [gsfp_pkg::BYTE_W-1:0]    running_sum_ff, running_sum_in;
   logic [gsfp_pkg::READING_W-1:0] held_tvoc_ff, held_tvoc_in;
   logic [gsfp_pkg::READING_W-1:0] held_form_ff, held_form_in;
   logic [gsfp_pkg::READING_W-1:0] held_eco2_ff, held_eco2_in;
   logic [gsfp_pkg::BYTE_W-1:0]    pending_ff [gsfp_pkg::PENDING_DEPTH];

   gsfp_pkg::result_type           result;
   gsfp_pkg::result_type           out_ff, skid_ff;
   logic                           out_valid_ff, skid_valid_ff;

   logic                           req_fire;
   logic                           res_fire;
   logic                           pend_we;
   logic [gsfp_pkg::PENDING_IDX_W-1:0] pend_idx;
   logic                           sum_ok;
   logic                           out_free;
   logic                           csr_wr;
   logic [gsfp_pkg::CSR_IDX_W-1:0] csr_idx;

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[gsfp_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= gsfp_pkg::HEADER_RESET;
      end else if (csr_wr && (csr_idx == gsfp_pkg::CSR_IDX_HEADER)) begin
         header_ff <= csr_pwdata[gsfp_pkg::BYTE_W-1:0];
      end
   end

   always_comb begin
      if (csr_idx == gsfp_pkg::CSR_IDX_HEADER) begin
         csr_prdata = gsfp_pkg::CSR_DATA_W'(header_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Frame parse
   // ------------------------------------------------------------------------
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign sum_ok    = (running_sum_ff == req_rx_byte);
   assign pend_idx  = gsfp_pkg::PENDING_IDX_W'(byte_count_ff - gsfp_pkg::FIRST_DATA_POS);

   always_comb begin
      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      held_tvoc_in   = held_tvoc_ff;
      held_form_in   = held_form_ff;
      held_eco2_in   = held_eco2_ff;
      res_fire       = 1'b0;
      pend_we        = 1'b0;
      if (req_fire) begin
         if (!in_frame_ff) begin
            // hunt for the header; it opens the running sum
            if (req_rx_byte == header_ff) begin
               in_frame_in    = 1'b1;
               byte_count_in  = gsfp_pkg::FIRST_POS;
               running_sum_in = req_rx_byte;
            end
         end else if (byte_count_ff < gsfp_pkg::CHECKSUM_POS) begin
            running_sum_in = running_sum_ff + req_rx_byte;
            pend_we        = (byte_count_ff >= gsfp_pkg::FIRST_DATA_POS);
            byte_count_in  = byte_count_ff + 4'd1;
         end else begin
            // checksum byte: latch readings on a match, always emit
            res_fire = 1'b1;
            if (sum_ok) begin
               held_tvoc_in = {pending_ff[0], pending_ff[1]};
               held_form_in = {pending_ff[2], pending_ff[3]};
               held_eco2_in = {pending_ff[4], pending_ff[5]};
            end
            in_frame_in    = 1'b0;
            byte_count_in  = '0;
            running_sum_in = '0;
         end
      end
   end

   always_comb begin
      result.frame_valid  = sum_ok;
      result.voc_reading  = held_tvoc_in;
      result.hcho_reading = held_form_in;
      result.co2_reading  = held_eco2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= '0;
         running_sum_ff <= '0;
         held_tvoc_ff   <= '0;
         held_form_ff   <= '0;
         held_eco2_ff   <= '0;
      end else begin
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         held_tvoc_ff   <= held_tvoc_in;
         held_form_ff   <= held_form_in;
         held_eco2_ff   <= held_eco2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pending_ff[pend_idx] <= req_rx_byte;
      end
   end

   // ------------------------------------------------------------------------
   // Output register with one-entry skid
   // ------------------------------------------------------------------------
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         // input is stalled while the skid is full, so no new result then
         out_valid_ff  <= skid_valid_ff || res_fire;
         skid_valid_ff <= 1'b0;
      end else if (res_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (res_fire) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_valid  = out_ff.frame_valid;
   assign rsp_voc_reading  = out_ff.voc_reading;
   assign rsp_hcho_reading = out_ff.hcho_reading;
   assign rsp_co2_reading  = out_ff.co2_reading;

endmodule

// ===== rtl/core/gsfp_checker.sv =====
// ----------------------------------------------------------------------------
// Gas sensor frame parser port checker
// Watches the top-level ports for flow and held-reading consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gas_sensor_frame_parser_core_assert.svh"

module gsfp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_frame_valid,
   input logic [gsfp_pkg::READING_W-1:0]     rsp_voc_reading,
   input logic [gsfp_pkg::READING_W-1:0]     rsp_hcho_reading,
   input logic [gsfp_pkg::READING_W-1:0]     rsp_co2_reading,
   input logic                               csr_pready
);

   logic [gsfp_pkg::READING_W-1:0] last_tvoc_ff;
   logic [gsfp_pkg::READING_W-1:0] last_form_ff;
   logic [gsfp_pkg::READING_W-1:0] last_eco2_ff;
   logic                           rsp_xfer;
   logic                           rsp_same_as_last;

   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign rsp_same_as_last = (rsp_voc_reading == last_tvoc_ff)
                          && (rsp_hcho_reading == last_form_ff)
                          && (rsp_co2_reading == last_eco2_ff);

   // track the readings of the last transferred result
   always_ff @(posedge clock) begin
      if (reset) begin
         last_tvoc_ff <= '0;
         last_form_ff <= '0;
         last_eco2_ff <= '0;
      end else if (rsp_xfer) begin
         last_tvoc_ff <= rsp_voc_reading;
         last_form_ff <= rsp_hcho_reading;
         last_eco2_ff <= rsp_co2_reading;
      end
   end

   `GSFP_ASSERT(a_bad_frame_repeats, clock, reset,
      !(rsp_xfer && !rsp_frame_valid) || rsp_same_as_last,
      "failed frame did not repeat the held readings")

   `GSFP_ASSERT(a_stall_only_with_result, clock, reset,
      !req_stall || rsp_valid,
      "input stalled while no result waits")

   `GSFP_ASSERT(a_pready_high, clock, reset,
      csr_pready,
      "register port not ready")

   `GSFP_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_frame_valid) && $stable(rsp_voc_reading)
         && $stable(rsp_hcho_reading) && $stable(rsp_co2_reading),
      "stalled result changed")

   `GSFP_ASSERT_NEXT(a_no_result_after_reset, clock, 1'b0,
      reset,
      !rsp_valid && !req_stall,
      "result or stall present right after reset")

endmodule

bind gas_sensor_frame_parser_core gsfp_checker u_gsfp_checker (.*);

// ===== tb/sv/tb_gas_sensor_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// Gas sensor frame parser core testbench
// Feeds byte streams of well-formed, corrupted and truncated frames under
// several header settings, with random sender gaps and random, periodic or
// held receiver stalls. Each result is checked by an in-bench parser model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class frame_scoreboard;
   logic [gsfp_pkg::BYTE_W-1:0]  header;
   bit                           in_frame;
   int unsigned                  pos;
   logic [gsfp_pkg::BYTE_W-1:0]  sum;
   logic [gsfp_pkg::BYTE_W-1:0]  body[gsfp_pkg::PENDING_DEPTH];
   gsfp_pkg::result_type         held;
   gsfp_pkg::result_type         expected_frames[$];
   int                           errors;
   int                           bytes_seen;
   int                           good_frames;
   int                           bad_frames;
   int                           results_checked;

   function new();
      header = gsfp_pkg::HEADER_RESET;
      in_frame = 0;
      pos = 0;
      sum = '0;
      foreach (body[i]) body[i] = '0;
      held = '0;
      errors = 0;
      bytes_seen = 0;
      good_frames = 0;
      bad_frames = 0;
      results_checked = 0;
   endfunction

   function void set_header(logic [gsfp_pkg::BYTE_W-1:0] value);
      header = value;
   endfunction

   // Track one accepted byte; queue a reading set on the checksum byte.
   function void note_byte(logic [gsfp_pkg::BYTE_W-1:0] b);
      gsfp_pkg::result_type res;
      bit ok;
      bytes_seen++;
      if (!in_frame) begin
         if (b == header) begin
            in_frame = 1;
            pos = 1;
            sum = b;
         end
         return;
      end
      if (pos < 8) begin
         sum = sum + b;
         if (pos >= 2) body[(pos - 2) % 6] = b;
         pos++;
         return;
      end
      ok = (sum == b);
      if (ok) begin
         held.voc_reading  = {body[0], body[1]};
         held.hcho_reading = {body[2], body[3]};
         held.co2_reading  = {body[4], body[5]};
         good_frames++;
      end else begin
         bad_frames++;
      end
      res = held;
      res.frame_valid = ok;
      expected_frames.push_back(res);
      in_frame = 0;
      pos = 0;
      sum = '0;
   endfunction

   task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
   endtask

   task check_result(gsfp_pkg::result_type got);
      gsfp_pkg::result_type want;
      if (expected_frames.size() == 0) begin
         report("result transfer with no frame outstanding");
         return;
      end
      want = expected_frames.pop_front();
      results_checked++;
      if (got.frame_valid !== want.frame_valid)
         report($sformatf("frame_valid got %0b want %0b", got.frame_valid,
                          want.frame_valid));
      if (got.voc_reading !== want.voc_reading)
         report($sformatf("voc_reading got %h want %h", got.voc_reading,
                          want.voc_reading));
      if (got.hcho_reading !== want.hcho_reading)
         report($sformatf("hcho_reading got %h want %h", got.hcho_reading,
                          want.hcho_reading));
      if (got.co2_reading !== want.co2_reading)
         report($sformatf("co2_reading got %h want %h", got.co2_reading,
                          want.co2_reading));
   endtask
endclass

module tb_gas_sensor_frame_parser_core;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 8;

   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   localparam logic [gsfp_pkg::CSR_ADDR_W-1:0] HEADER_ADDR =
      {gsfp_pkg::CSR_IDX_HEADER, 2'b00};

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [gsfp_pkg::BYTE_W-1:0]         req_rx_byte;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic                                rsp_frame_valid;
   logic [gsfp_pkg::READING_W-1:0]      rsp_voc_reading;
   logic [gsfp_pkg::READING_W-1:0]      rsp_hcho_reading;
   logic [gsfp_pkg::READING_W-1:0]      rsp_co2_reading;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [gsfp_pkg::CSR_ADDR_W-1:0]     csr_paddr;
   logic [gsfp_pkg::CSR_DATA_W-1:0]     csr_pwdata;
   logic [gsfp_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   frame_scoreboard sb = new();

   logic [gsfp_pkg::BYTE_W-1:0] cur_header = gsfp_pkg::HEADER_RESET;
   int  stall_mode = STALL_NONE;
   int  gap_max = 0;
   int  burst_left = 0;
   bit  hold_req = 0;
   int  quiet_cycles = 0;
   int  header_writes = 0;

   gas_sensor_frame_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_valid  (rsp_frame_valid),
      .rsp_voc_reading  (rsp_voc_reading),
      .rsp_hcho_reading (rsp_hcho_reading),
      .rsp_co2_reading  (rsp_co2_reading),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Observe transfers on both channels at the clock edge.
   always @(posedge clock) begin
      gsfp_pkg::result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            got.frame_valid  = rsp_frame_valid;
            got.voc_reading  = rsp_voc_reading;
            got.hcho_reading = rsp_hcho_reading;
            got.co2_reading  = rsp_co2_reading;
            sb.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable && csr_pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: stall pattern per phase, plus a long hold-off on request.
   initial begin
      int holding;
      int tick;
      holding = 0;
      tick = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_req) begin
            hold_req = 0;
            holding = HOLD_CYCLES;
         end
         if (holding > 0) begin
            holding--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 25);
               STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 75);
               STALL_PERIODIC: rsp_stall <= ((tick % 7) < 3);
               default:        rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // Offer one byte and hold it until the transfer; gaps fall between bursts.
   task automatic send_byte(logic [gsfp_pkg::BYTE_W-1:0] b);
      if (gap_max > 0 && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   // Body byte: mostly random, with extremes and the header value mixed in.
   function automatic logic [gsfp_pkg::BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 8'h00;
      if (r < 16) return 8'hFF;
      if (r < 22) return cur_header;
      return gsfp_pkg::BYTE_W'($urandom);
   endfunction

   // Send a frame: good or corrupted checksum, optionally cut after cut bytes.
   task automatic send_frame(bit good, int cut, output int sent);
      logic [gsfp_pkg::BYTE_W-1:0] bytes[9];
      logic [gsfp_pkg::BYTE_W-1:0] total;
      int n;
      bytes[0] = cur_header;
      total = cur_header;
      for (int i = 1; i < 8; i++) begin
         bytes[i] = pick_byte();
         total = total + bytes[i];
      end
      bytes[8] = good ? total : total + gsfp_pkg::BYTE_W'($urandom_range(1, 255));
      n = (cut > 0 && cut < 9) ? cut : 9;
      for (int i = 0; i < n; i++) send_byte(bytes[i]);
      sent = n;
   endtask

   task automatic run_random(int n_bytes);
      int sent;
      int cnt;
      int r;
      sent = 0;
      while (sent < n_bytes) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            send_frame($urandom_range(0, 99) < 85, 0, cnt);
         end else if (r < 85) begin
            send_frame(1'b1, $urandom_range(1, 8), cnt);
         end else begin
            cnt = $urandom_range(1, 4);
            repeat (cnt) send_byte(gsfp_pkg::BYTE_W'($urandom));
         end
         sent += cnt;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Write the header register, then read it back.
   task automatic write_header(logic [gsfp_pkg::BYTE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= HEADER_ADDR;
      csr_pwdata  <= gsfp_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_header(value);
      cur_header = value;
      header_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[gsfp_pkg::BYTE_W-1:0] !== value)
         sb.report($sformatf("header readback got %h want %h",
                             csr_prdata[gsfp_pkg::BYTE_W-1:0], value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [gsfp_pkg::BYTE_W-1:0] phase_headers[6];
      int stall_modes[6];
      int gaps[6];
      int cnt;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bytes ignored while hunting, a corrupted frame before any
      // good one (readings stay zero) with the header value inside it, then a
      // good frame of all-ones readings.
      stall_mode = STALL_LIGHT;
      send_byte(8'h00);
      send_byte(8'hFF);
      begin
         logic [gsfp_pkg::BYTE_W-1:0] frame_bad[9];
         logic [gsfp_pkg::BYTE_W-1:0] frame_ones[9];
         frame_bad  = '{8'h2C, 8'h2C, 8'h12, 8'h2C, 8'h00, 8'hFF, 8'h2C, 8'h80, 8'h00};
         frame_ones = '{8'h2C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h25};
         foreach (frame_bad[i]) send_byte(frame_bad[i]);
         foreach (frame_ones[i]) send_byte(frame_ones[i]);
      end
      send_frame(1'b1, 0, cnt);
      wait_drained();

      phase_headers = '{gsfp_pkg::HEADER_RESET, 8'h00, 8'hFF, 8'h00, 8'h00,
                        gsfp_pkg::HEADER_RESET};
      phase_headers[3] = gsfp_pkg::BYTE_W'($urandom);
      phase_headers[4] = gsfp_pkg::BYTE_W'($urandom);
      stall_modes = '{STALL_NONE, STALL_LIGHT, STALL_NONE, STALL_HEAVY,
                      STALL_PERIODIC, STALL_LIGHT};
      gaps = '{0, 6, 0, 20, 3, 10};

      for (int p = 0; p < 6; p++) begin
         if (p > 0) write_header(phase_headers[p]);
         stall_mode = stall_modes[p];
         gap_max = gaps[p];
         burst_left = 0;
         // Hold off the receiver while bytes keep coming so the core backs up.
         if (p == 2) hold_req = 1;
         run_random(150);
         // Leave a frame open across the next header change.
         if (p == 1 || p == 3) send_frame(1'b1, $urandom_range(2, 7), cnt);
         wait_drained();
      end

      $display("covered %0d bytes, %0d good and %0d corrupted frames, %0d results",
               sb.bytes_seen, sb.good_frames, sb.bad_frames, sb.results_checked);
      $display("header register written %0d times incl. 0x00 and 0xFF", header_writes);
      if (sb.errors == 0 && sb.expected_frames.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
